// File: design/lps_pkg.sv
// lps_pkg: shared types and constants for the lasso selection block.
// Used by lps_ctrl, lps_dp and lasso_polygon_selection. No dependencies.
`timescale 1ns / 1ps

package lps_pkg;

  // fixed point layout of stored coordinates
  localparam int COORD_FRAC_BITS = 4;
  localparam int CanvasW         = 12;
  localparam int CoordW          = CanvasW + COORD_FRAC_BITS;  // clamped, unsigned
  localparam int PosW            = 17;                         // input, signed
  localparam int CmdW            = 3;

  // configuration register indexes
  localparam logic CFG_CANVAS_WIDTH  = 1'b0;
  localparam logic CFG_CANVAS_HEIGHT = 1'b1;

  localparam logic [CanvasW-1:0] CanvasReset = 12'd1024;

  typedef enum logic [CmdW-1:0] {
    CMD_START = 3'd0,
    CMD_ADD   = 3'd1,
    CMD_END   = 3'd2,
    CMD_QUERY = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_INACTIVE = 2'd0,
    MODE_DRAWING  = 2'd1,
    MODE_SELECTED = 2'd2
  } mode_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // item taken this cycle, apply command / arm query
    logic walk;    // read next vertex of the crossing walk
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic query_go;   // current command is a query that needs the walk
    logic walk_last;  // read pointer is at the last stored vertex
  } sts_t;

  // clamp a signed coordinate to [0, canvas << frac]
  function automatic logic [CoordW-1:0] clamp_coord(input logic [PosW-1:0] v,
                                                    input logic [CanvasW-1:0] canvas);
    logic [CoordW-1:0] hi;
    hi = CoordW'(canvas) << COORD_FRAC_BITS;
    if (v[PosW-1]) begin
      return '0;
    end else if (v[CoordW-1:0] > hi) begin
      return hi;
    end else begin
      return v[CoordW-1:0];
    end
  endfunction

endpackage

// File: design/lasso_polygon_selection.sv
// lasso_polygon_selection: top level of the lasso selection engine.
// Depends on lps_pkg, lps_ctrl, lps_dp (and lps_ram below it).
//
// Command channel: drive command_i, x_pos_i, y_pos_i and raise start; the
//   item is taken on a rising edge with start high and busy low.
//   Commands: start lasso, add point, end lasso, query point, clear.
// Result: one per item, shown for exactly one cycle with done_o high.
//   inside_res_o and dropped_o belong to that item; mode_o, point_count_o
//   and the box ports show the state after it.
// Config: cfg_valid_i/cfg_ready_o, cfg_index_i (0 canvas width, 1 canvas
//   height, whole pixels) and cfg_data_i. Always ready; write only while idle.
// Timing: start, add, end, clear, and queries rejected by mode, box or
//   point count give done_o in the cycle after the accept with busy low, so
//   one such item per cycle. A query that passes the box test reads every
//   stored vertex through the single RAM read port, one per cycle, then
//   passes the multiply and compare pipeline stages before done_o, and busy
//   holds off the next item.
// Reset: mode inactive, no points, box zero, canvas 1024 x 1024. The vertex
//   RAM is not cleared; only written entries are ever read. The receiver
//   cannot stall: results are not held.
`timescale 1ns / 1ps

module lasso_polygon_selection
  import lps_pkg::*;
#(
  parameter int MAX_POINTS = 256,
  localparam int CntW = $clog2(MAX_POINTS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command channel
  input  logic               start,
  output logic               busy,
  input  logic [CmdW-1:0]    command_i,
  input  logic [PosW-1:0]    x_pos_i,
  input  logic [PosW-1:0]    y_pos_i,
  // results
  output logic               done_o,
  output logic               inside_res_o,
  output logic [1:0]         mode_o,
  output logic [CntW-1:0]    point_count_o,
  output logic               dropped_o,
  output logic [CoordW-1:0]  box_left_o,
  output logic [CoordW-1:0]  box_top_o,
  output logic [CoordW-1:0]  box_right_o,
  output logic [CoordW-1:0]  box_bottom_o,
  // configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [CanvasW-1:0] cfg_data_i
);

  logic [CanvasW-1:0] canvas_w_q, canvas_h_q;
  ctl_t ctl;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_w_q <= CanvasReset;
      canvas_h_q <= CanvasReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_CANVAS_WIDTH:  canvas_w_q <= cfg_data_i;
        CFG_CANVAS_HEIGHT: canvas_h_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  lps_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .ctl_o  (ctl),
    .sts_i  (sts)
  );

  lps_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .command_i     (command_i),
    .x_pos_i       (x_pos_i),
    .y_pos_i       (y_pos_i),
    .canvas_w_i    (canvas_w_q),
    .canvas_h_i    (canvas_h_q),
    .inside_res_o  (inside_res_o),
    .mode_o        (mode_o),
    .point_count_o (point_count_o),
    .dropped_o     (dropped_o),
    .box_left_o    (box_left_o),
    .box_top_o     (box_top_o),
    .box_right_o   (box_right_o),
    .box_bottom_o  (box_bottom_o)
  );

  // a short item reports in the very next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i != CMD_QUERY) |=> done_o)
    else $error("short command did not report next cycle");

  // stored points never exceed the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_count_o <= CntW'(MAX_POINTS))
    else $error("point count beyond store depth");

  // a selected lasso is always a closed polygon of more than two points
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_o == MODE_SELECTED) |-> (point_count_o > CntW'(2)))
    else $error("selected with too few points");

  // an inside answer needs a selected lasso
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && inside_res_o) |-> (mode_o == MODE_SELECTED))
    else $error("inside reported outside selected mode");

endmodule

// File: design/lps_ram.sv
// lps_ram: generic single write port, single read port RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps

module lps_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: design/lps_ctrl.sv
// lps_ctrl: sequencer for the lasso block; accepts items, runs the edge walk.
// Depends on lps_pkg.
`timescale 1ns / 1ps

module lps_ctrl
  import lps_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  output logic done_o,
  output ctl_t ctl_o,
  input  sts_t sts_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FLUSH1,
    S_FLUSH2
  } state_e;

  state_e state_q;
  logic   done_q;
  logic   accept;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign done_o = done_q;

  assign ctl_o.accept = accept;
  assign ctl_o.walk   = (state_q == S_WALK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          // short items report right away, a live query starts the walk
          done_q <= accept && !sts_i.query_go;
          if (accept && sts_i.query_go) begin
            state_q <= S_WALK;
          end
        end
        S_WALK: begin
          done_q <= 1'b0;
          if (sts_i.walk_last) begin
            state_q <= S_FLUSH1;
          end
        end
        S_FLUSH1: begin
          done_q  <= 1'b0;
          state_q <= S_FLUSH2;
        end
        S_FLUSH2: begin
          state_q <= S_IDLE;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= S_IDLE;
          done_q  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// File: design/lps_dp.sv
// lps_dp: lasso datapath - path state, vertex store, running box and the
// two-stage cross-multiply crossing pipeline. Depends on lps_pkg, lps_ram.
`timescale 1ns / 1ps

module lps_dp
  import lps_pkg::*;
#(
  parameter int MAX_POINTS = 256,
  localparam int AddrW = $clog2(MAX_POINTS),
  localparam int CntW  = $clog2(MAX_POINTS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctl_t               ctl_i,
  output sts_t               sts_o,
  input  logic [CmdW-1:0]    command_i,
  input  logic [PosW-1:0]    x_pos_i,
  input  logic [PosW-1:0]    y_pos_i,
  input  logic [CanvasW-1:0] canvas_w_i,
  input  logic [CanvasW-1:0] canvas_h_i,
  output logic               inside_res_o,
  output logic [1:0]         mode_o,
  output logic [CntW-1:0]    point_count_o,
  output logic               dropped_o,
  output logic [CoordW-1:0]  box_left_o,
  output logic [CoordW-1:0]  box_top_o,
  output logic [CoordW-1:0]  box_right_o,
  output logic [CoordW-1:0]  box_bottom_o
);

  localparam int ProdW = 35;

  // control state
  mode_e             mode_q, mode_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CoordW-1:0] last_x_q, last_x_d, last_y_q, last_y_d;
  logic [CoordW-1:0] left_q, left_d, top_q, top_d, right_q, right_d, bot_q, bot_d;
  logic              inside_q, inside_d, dropped_q, dropped_d;
  logic [AddrW-1:0]  idx_q, idx_d;
  logic              rd_v_q, cond_q;

  // payload
  logic [CoordW-1:0] first_x_q, first_x_d, first_y_q, first_y_d;
  logic [CoordW-1:0] rl_q, rl_d, rt_q, rt_d, rr_q, rr_d, rb_q, rb_d;
  logic [PosW-1:0]   px_q, px_d, py_q, py_d;
  logic [CoordW-1:0] prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic signed [ProdW-1:0] lhs_q, rhs_q;
  logic              dypos_q;

  // memory port
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [2*CoordW-1:0] mem_wdata, mem_rdata;

  logic [CoordW-1:0] cx, cy;
  logic              in_box;

  assign cx = clamp_coord(x_pos_i, canvas_w_i);
  assign cy = clamp_coord(y_pos_i, canvas_h_i);

  // half-open box test on the raw query point
  assign in_box = !x_pos_i[PosW-1] && !y_pos_i[PosW-1]
               && (x_pos_i[CoordW-1:0] >= left_q) && (x_pos_i[CoordW-1:0] < right_q)
               && (y_pos_i[CoordW-1:0] >= top_q)  && (y_pos_i[CoordW-1:0] < bot_q);

  assign sts_o.query_go  = (command_i == CMD_QUERY) && (mode_q == MODE_SELECTED)
                        && in_box && (count_q > CntW'(2));
  assign sts_o.walk_last = (CntW'(idx_q) == (count_q - CntW'(1)));

  lps_ram #(
    .Width (2 * CoordW),
    .Depth (MAX_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (idx_q),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    mode_d    = mode_q;
    count_d   = count_q;
    last_x_d  = last_x_q;
    last_y_d  = last_y_q;
    left_d    = left_q;
    top_d     = top_q;
    right_d   = right_q;
    bot_d     = bot_q;
    inside_d  = inside_q;
    dropped_d = dropped_q;
    idx_d     = idx_q;
    first_x_d = first_x_q;
    first_y_d = first_y_q;
    rl_d      = rl_q;
    rt_d      = rt_q;
    rr_d      = rr_q;
    rb_d      = rb_q;
    px_d      = px_q;
    py_d      = py_q;
    mem_we    = 1'b0;
    mem_waddr = count_q[AddrW-1:0];
    mem_wdata = {cx, cy};

    if (ctl_i.accept) begin
      inside_d  = 1'b0;
      dropped_d = 1'b0;
      px_d      = x_pos_i;
      py_d      = y_pos_i;
      idx_d     = '0;
      unique case (command_i)
        CMD_START: begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          count_d   = CntW'(1);
          last_x_d  = cx;
          last_y_d  = cy;
          first_x_d = cx;
          first_y_d = cy;
          rl_d      = cx;
          rr_d      = cx;
          rt_d      = cy;
          rb_d      = cy;
          mode_d    = MODE_DRAWING;
        end
        CMD_ADD: begin
          if (mode_q == MODE_DRAWING &&
              (count_q == '0 || cx != last_x_q || cy != last_y_q)) begin
            if (count_q >= CntW'(MAX_POINTS - 1)) begin
              dropped_d = 1'b1;
            end else begin
              mem_we   = 1'b1;
              count_d  = count_q + CntW'(1);
              last_x_d = cx;
              last_y_d = cy;
              if (cx < rl_q) rl_d = cx;
              if (cx > rr_q) rr_d = cx;
              if (cy < rt_q) rt_d = cy;
              if (cy > rb_q) rb_d = cy;
            end
          end
        end
        CMD_END: begin
          if (mode_q == MODE_DRAWING) begin
            if (count_q > CntW'(2)) begin
              // close the path; the first point is already in the running box
              if (first_x_q != last_x_q || first_y_q != last_y_q) begin
                mem_we    = 1'b1;
                mem_wdata = {first_x_q, first_y_q};
                count_d   = count_q + CntW'(1);
                last_x_d  = first_x_q;
                last_y_d  = first_y_q;
              end
              left_d  = rl_q;
              top_d   = rt_q;
              right_d = rr_q;
              bot_d   = rb_q;
              mode_d  = MODE_SELECTED;
            end else begin
              mode_d = MODE_INACTIVE;
            end
          end
        end
        CMD_QUERY: begin
        end
        CMD_CLEAR: begin
          mode_d   = MODE_INACTIVE;
          count_d  = '0;
          last_x_d = '0;
          last_y_d = '0;
          left_d   = '0;
          top_d    = '0;
          right_d  = '0;
          bot_d    = '0;
        end
        default: begin
        end
      endcase
    end

    if (ctl_i.walk) begin
      idx_d = idx_q + AddrW'(1);
    end

    // crossing stage 2: compare the products, toggle parity
    if (cond_q && (dypos_q ? (lhs_q < rhs_q) : (lhs_q > rhs_q))) begin
      inside_d = !inside_q;
    end
  end

  // crossing stage 1: edge from previous vertex (j) to the one just read (i)
  logic [CoordW-1:0]       xi, yi;
  logic signed [PosW+1:0]  py_e, yi_e, yj_e;
  logic signed [PosW-1:0]  dy, dxj;
  logic signed [PosW:0]    dxp, dyp;
  logic signed [ProdW-1:0] lhs_d, rhs_d;
  logic                    straddle;

  assign xi   = mem_rdata[2*CoordW-1:CoordW];
  assign yi   = mem_rdata[CoordW-1:0];
  assign py_e = $signed({{2{py_q[PosW-1]}}, py_q});
  assign yi_e = $signed({3'b000, yi});
  assign yj_e = $signed({3'b000, prev_y_q});
  assign straddle = (yi_e > py_e) != (yj_e > py_e);
  assign dy   = $signed({1'b0, prev_y_q}) - $signed({1'b0, yi});
  assign dxj  = $signed({1'b0, prev_x_q}) - $signed({1'b0, xi});
  assign dxp  = $signed({px_q[PosW-1], px_q}) - $signed({2'b00, xi});
  assign dyp  = $signed({py_q[PosW-1], py_q}) - $signed({2'b00, yi});
  assign lhs_d = ProdW'(dxp) * ProdW'(dy);
  assign rhs_d = ProdW'(dxj) * ProdW'(dyp);

  always_comb begin
    prev_x_d = prev_x_q;
    prev_y_d = prev_y_q;
    if (ctl_i.accept) begin
      // edge into vertex 0 comes from the last stored vertex
      prev_x_d = last_x_q;
      prev_y_d = last_y_q;
    end else if (rd_v_q) begin
      prev_x_d = xi;
      prev_y_d = yi;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_INACTIVE;
      count_q   <= '0;
      last_x_q  <= '0;
      last_y_q  <= '0;
      left_q    <= '0;
      top_q     <= '0;
      right_q   <= '0;
      bot_q     <= '0;
      inside_q  <= 1'b0;
      dropped_q <= 1'b0;
      idx_q     <= '0;
      rd_v_q    <= 1'b0;
      cond_q    <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      count_q   <= count_d;
      last_x_q  <= last_x_d;
      last_y_q  <= last_y_d;
      left_q    <= left_d;
      top_q     <= top_d;
      right_q   <= right_d;
      bot_q     <= bot_d;
      inside_q  <= inside_d;
      dropped_q <= dropped_d;
      idx_q     <= idx_d;
      rd_v_q    <= ctl_i.walk;
      cond_q    <= rd_v_q && straddle;
    end
  end

  always_ff @(posedge clk_i) begin
    first_x_q <= first_x_d;
    first_y_q <= first_y_d;
    rl_q      <= rl_d;
    rt_q      <= rt_d;
    rr_q      <= rr_d;
    rb_q      <= rb_d;
    px_q      <= px_d;
    py_q      <= py_d;
    prev_x_q  <= prev_x_d;
    prev_y_q  <= prev_y_d;
    lhs_q     <= lhs_d;
    rhs_q     <= rhs_d;
    dypos_q   <= !dy[PosW-1] && (dy != '0);
  end

  assign inside_res_o  = inside_q;
  assign mode_o        = mode_q;
  assign point_count_o = count_q;
  assign dropped_o     = dropped_q;
  assign box_left_o    = left_q;
  assign box_top_o     = top_q;
  assign box_right_o   = right_q;
  assign box_bottom_o  = bot_q;

endmodule

// File: dv/tb_top.sv
// tb_top: self-checking testbench for lasso_polygon_selection.
// Depends on lps_pkg, lasso_polygon_selection and the design files below it.
`timescale 1ns / 1ps

module tb_top;
  import lps_pkg::*;

  localparam int MAX_PTS        = 256;
  localparam int CntW           = $clog2(MAX_PTS + 1);
  localparam int WATCHDOG_LIMIT = 3000;  // far above the longest query walk; sender gaps are short
  localparam int MAX_ROWS       = 32;

  // command codes the block has no meaning for
  localparam logic [CmdW-1:0] CMD_RSVD_LO = 3'd5;
  localparam logic [CmdW-1:0] CMD_RSVD_HI = 3'd7;

  // input extremes, 17 bit two's complement
  localparam logic [PosW-1:0] POS_MIN = 17'h10000;
  localparam logic [PosW-1:0] POS_MAX = 17'h0FFFF;

  // what one result item carries
  typedef struct packed {
    logic              in_poly;
    logic [1:0]        mode;
    logic [CntW-1:0]   count;
    logic              dropped;
    logic [CoordW-1:0] left;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] right;
    logic [CoordW-1:0] bottom;
  } status_t;

  // one row of the directed stimulus; typed rows carry their own answer
  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic [PosW-1:0] x;
    logic [PosW-1:0] y;
    logic            typed;
    status_t         exp;
  } stim_row_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               start       = 1'b0;
  logic               busy;
  logic [CmdW-1:0]    command_i   = CMD_CLEAR;
  logic [PosW-1:0]    x_pos_i     = '0;
  logic [PosW-1:0]    y_pos_i     = '0;
  logic               done_o;
  logic               inside_res_o;
  logic [1:0]         mode_o;
  logic [CntW-1:0]    point_count_o;
  logic               dropped_o;
  logic [CoordW-1:0]  box_left_o;
  logic [CoordW-1:0]  box_top_o;
  logic [CoordW-1:0]  box_right_o;
  logic [CoordW-1:0]  box_bottom_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_index_i = CFG_CANVAS_WIDTH;
  logic [CanvasW-1:0] cfg_data_i  = '0;

  lasso_polygon_selection #(
    .MAX_POINTS(MAX_PTS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .command_i    (command_i),
    .x_pos_i      (x_pos_i),
    .y_pos_i      (y_pos_i),
    .done_o       (done_o),
    .inside_res_o (inside_res_o),
    .mode_o       (mode_o),
    .point_count_o(point_count_o),
    .dropped_o    (dropped_o),
    .box_left_o   (box_left_o),
    .box_top_o    (box_top_o),
    .box_right_o  (box_right_o),
    .box_bottom_o (box_bottom_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Lasso model: mirror of the block's state, advanced once per accepted
  // item in the same order the block takes them.
  // ---------------------------------------------------------------------
  logic [CanvasW-1:0] canvas_w = CanvasReset;
  logic [CanvasW-1:0] canvas_h = CanvasReset;
  mode_e              cur_mode = MODE_INACTIVE;
  logic [CoordW-1:0]  vx[MAX_PTS];
  logic [CoordW-1:0]  vy[MAX_PTS];
  int                 n_pts    = 0;
  logic [CoordW-1:0]  last_x   = '0;
  logic [CoordW-1:0]  last_y   = '0;
  logic [CoordW-1:0]  box_l    = '0;
  logic [CoordW-1:0]  box_t    = '0;
  logic [CoordW-1:0]  box_r    = '0;
  logic [CoordW-1:0]  box_b    = '0;

  status_t pending_status[$];  // answers owed by the block, oldest first
  int      n_sent   = 0;
  int      n_seen   = 0;
  int      errors   = 0;
  int      idle_pct = 0;       // chance in 100 that the sender skips a cycle

  // clamp a signed input to [0, canvas << frac]
  function automatic logic [CoordW-1:0] clamp_axis(input logic [PosW-1:0] v,
                                                   input logic [CanvasW-1:0] lim);
    int hi;
    int s;
    hi = int'(lim) << COORD_FRAC_BITS;
    s  = int'($signed(v));
    if (s < 0) begin
      return '0;
    end else if (s > hi) begin
      return CoordW'(hi);
    end
    return CoordW'(s);
  endfunction

  // append a vertex; the store never grows past MAX_PTS
  function automatic void store_vertex(input logic [CoordW-1:0] x,
                                       input logic [CoordW-1:0] y);
    if (n_pts < MAX_PTS) begin
      vx[n_pts] = x;
      vy[n_pts] = y;
      n_pts++;
    end
    last_x = x;
    last_y = y;
  endfunction

  // even-odd crossing walk, exact through cross-multiplication
  function automatic logic crossing_parity(input longint px, input longint py);
    logic   odd;
    int     j;
    longint xi, yi, xj, yj, dy, lhs, rhs;
    odd = 1'b0;
    j   = n_pts - 1;
    for (int i = 0; i < n_pts; i++) begin
      xi = longint'(vx[i]);
      yi = longint'(vy[i]);
      xj = longint'(vx[j]);
      yj = longint'(vy[j]);
      if ((yi > py) != (yj > py)) begin
        dy  = yj - yi;
        lhs = (px - xi) * dy;
        rhs = (xj - xi) * (py - yi);
        if ((dy > 0) ? (lhs < rhs) : (lhs > rhs)) begin
          odd = !odd;
        end
      end
      j = i;
    end
    return odd;
  endfunction

  // apply one command to the model and return the status it leaves
  function automatic status_t apply_command(input logic [CmdW-1:0] cmd,
                                            input logic [PosW-1:0] xin,
                                            input logic [PosW-1:0] yin);
    status_t           r;
    logic [CoordW-1:0] cx, cy;
    int                px, py;
    r  = '0;
    cx = clamp_axis(xin, canvas_w);
    cy = clamp_axis(yin, canvas_h);
    px = int'($signed(xin));
    py = int'($signed(yin));
    case (cmd)
      CMD_START: begin
        n_pts = 0;
        store_vertex(cx, cy);
        cur_mode = MODE_DRAWING;
      end
      CMD_ADD: begin
        // repeats of the last point are skipped, not flagged
        if (cur_mode == MODE_DRAWING && (n_pts == 0 || cx != last_x || cy != last_y)) begin
          if (n_pts >= MAX_PTS - 1) begin
            r.dropped = 1'b1;
          end else begin
            store_vertex(cx, cy);
          end
        end
      end
      CMD_END: begin
        if (cur_mode == MODE_DRAWING) begin
          if (n_pts > 2) begin
            if (vx[0] != last_x || vy[0] != last_y) begin
              store_vertex(vx[0], vy[0]);
            end
            box_l = vx[0];
            box_r = vx[0];
            box_t = vy[0];
            box_b = vy[0];
            for (int i = 1; i < n_pts; i++) begin
              if (vx[i] < box_l) box_l = vx[i];
              if (vx[i] > box_r) box_r = vx[i];
              if (vy[i] < box_t) box_t = vy[i];
              if (vy[i] > box_b) box_b = vy[i];
            end
            cur_mode = MODE_SELECTED;
          end else begin
            // too short to close: drop back, keep points and box
            cur_mode = MODE_INACTIVE;
          end
        end
      end
      CMD_QUERY: begin
        // half-open box first, then the crossing walk; query point is not clamped
        if (cur_mode == MODE_SELECTED && n_pts > 2 &&
            px >= int'(box_l) && px < int'(box_r) &&
            py >= int'(box_t) && py < int'(box_b)) begin
          r.in_poly = crossing_parity(longint'(px), longint'(py));
        end
      end
      CMD_CLEAR: begin
        cur_mode = MODE_INACTIVE;
        n_pts    = 0;
        last_x   = '0;
        last_y   = '0;
        box_l    = '0;
        box_t    = '0;
        box_r    = '0;
        box_b    = '0;
      end
      default: ;  // unused codes only report status
    endcase
    r.mode   = cur_mode;
    r.count  = CntW'(n_pts);
    r.left   = box_l;
    r.top    = box_t;
    r.right  = box_r;
    r.bottom = box_b;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Sender side. Inputs move on the falling edge; an item is taken at the
  // rising edge with start high and busy low, and the model advances there.
  // ---------------------------------------------------------------------
  task automatic send_item(input logic [CmdW-1:0] cmd,
                           input logic [PosW-1:0] x,
                           input logic [PosW-1:0] y,
                           input logic typed = 1'b0,
                           input status_t typed_exp = '0);
    status_t want;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start     <= 1'b1;
    command_i <= cmd;
    x_pos_i   <= x;
    y_pos_i   <= y;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    want = apply_command(cmd, x, y);
    pending_status.insert(pending_status.size(), typed ? typed_exp : want);
    n_sent++;
  endtask

  // hold off until the block owes nothing
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_canvas(input logic idx, input logic [CanvasW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_CANVAS_WIDTH) begin
      canvas_w = val;
    end else begin
      canvas_h = val;
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly on the canvas, some past its edge, some anywhere in the field
  function automatic logic [PosW-1:0] pick_coord(input logic [CanvasW-1:0] lim);
    int hi;
    hi = int'(lim) << COORD_FRAC_BITS;
    case ($urandom_range(9))
      0:       return PosW'($urandom);
      1:       return PosW'(hi + 1 + int'($urandom_range(63)));
      default: return PosW'($urandom_range(hi));
    endcase
  endfunction

  // start, a run of adds (some repeats), usually an end, then queries
  // aimed at the box or right on a vertex, and now and then a clear
  task automatic draw_lasso(input int n_adds, input int n_queries);
    logic [PosW-1:0] qx, qy;
    int              k;
    send_item(CMD_START, pick_coord(canvas_w), pick_coord(canvas_h));
    repeat (n_adds) begin
      if ($urandom_range(9) == 0) begin
        send_item(CMD_ADD, PosW'(last_x), PosW'(last_y));
      end else begin
        send_item(CMD_ADD, pick_coord(canvas_w), pick_coord(canvas_h));
      end
    end
    if ($urandom_range(19) != 0) begin
      send_item(CMD_END, PosW'($urandom), PosW'($urandom));
    end
    repeat (n_queries) begin
      if (cur_mode == MODE_SELECTED && $urandom_range(3) == 0) begin
        k  = $urandom_range(n_pts - 1);
        qx = PosW'(vx[k]);
        qy = PosW'(vy[k]);
      end else begin
        qx = PosW'(int'(box_l) - 8 + int'($urandom_range(int'(box_r) - int'(box_l) + 16)));
        qy = PosW'(int'(box_t) - 8 + int'($urandom_range(int'(box_b) - int'(box_t) + 16)));
      end
      send_item(CMD_QUERY, qx, qy);
    end
    if ($urandom_range(7) == 0) begin
      send_item(CMD_CLEAR, PosW'($urandom), PosW'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------
  // Result side: every strobe is matched against the oldest answer owed.
  // ---------------------------------------------------------------------
  task automatic flag_mismatch(input string field, input longint got, input longint want);
    errors++;
    $display("mismatch on result %0d, %s: got %0h, want %0h", n_seen, field, got, want);
  endtask

  always @(posedge clk_i) begin
    status_t got;
    status_t want;
    if (rst_ni && done_o) begin
      got = '{inside_res_o, mode_o, point_count_o, dropped_o,
              box_left_o, box_top_o, box_right_o, box_bottom_o};
      if (pending_status.size() == 0) begin
        flag_mismatch("unexpected result", 0, 0);
      end else begin
        want = pending_status.pop_front();
        if (got.in_poly !== want.in_poly) flag_mismatch("inside_res", got.in_poly, want.in_poly);
        if (got.mode !== want.mode)       flag_mismatch("mode", got.mode, want.mode);
        if (got.count !== want.count)     flag_mismatch("point_count", got.count, want.count);
        if (got.dropped !== want.dropped) flag_mismatch("dropped", got.dropped, want.dropped);
        if (got.left !== want.left)       flag_mismatch("box_left", got.left, want.left);
        if (got.top !== want.top)         flag_mismatch("box_top", got.top, want.top);
        if (got.right !== want.right)     flag_mismatch("box_right", got.right, want.right);
        if (got.bottom !== want.bottom)   flag_mismatch("box_bottom", got.bottom, want.bottom);
      end
      n_seen++;
    end
  end

  // ends the run when nothing moves on any channel for too long
  int stall_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Sequence: reset, directed rows, then five random phases with different
  // canvas sizes and sender gaps.
  // ---------------------------------------------------------------------
  stim_row_t directed_rows[MAX_ROWS];
  int        n_rows = 0;

  function automatic void add_row(input stim_row_t row);
    directed_rows[n_rows] = row;
    n_rows++;
  endfunction

  initial begin
    int goal;
    // status right after reset; also what ignored commands must leave alone
    add_row(stim_row_t'{CMD_QUERY, 17'd0, 17'd0, 1'b1,
        status_t'{1'b0, MODE_INACTIVE, 9'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0}});
    add_row(stim_row_t'{CMD_ADD, 17'd5, 17'd5, 1'b1,
        status_t'{1'b0, MODE_INACTIVE, 9'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0}});
    add_row(stim_row_t'{CMD_END, 17'd0, 17'd0, 1'b1,
        status_t'{1'b0, MODE_INACTIVE, 9'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0}});
    add_row(stim_row_t'{CMD_RSVD_LO, 17'd3, 17'd3, 1'b1,
        status_t'{1'b0, MODE_INACTIVE, 9'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0}});
    add_row(stim_row_t'{CMD_RSVD_HI, POS_MIN, POS_MAX, 1'b1,
        status_t'{1'b0, MODE_INACTIVE, 9'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0}});
    // clamp at both ends: most negative goes to 0, most positive to 1024 px
    add_row(stim_row_t'{CMD_START, POS_MIN, POS_MIN, 1'b1,
        status_t'{1'b0, MODE_DRAWING, 9'd1, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0}});
    add_row(stim_row_t'{CMD_ADD, POS_MAX, POS_MAX, 1'b1,
        status_t'{1'b0, MODE_DRAWING, 9'd2, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0}});
    // clamps onto the last point, so it is skipped
    add_row(stim_row_t'{CMD_ADD, 17'd20000, POS_MAX, 1'b1,
        status_t'{1'b0, MODE_DRAWING, 9'd2, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0}});
    // two points only: back to inactive, points kept
    add_row(stim_row_t'{CMD_END, 17'd0, 17'd0, 1'b1,
        status_t'{1'b0, MODE_INACTIVE, 9'd2, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0}});
    // square 10..30 px, closed by end
    add_row(stim_row_t'{CMD_START, 17'd160, 17'd160, 1'b0, '0});
    add_row(stim_row_t'{CMD_ADD, 17'd480, 17'd160, 1'b0, '0});
    add_row(stim_row_t'{CMD_ADD, 17'd480, 17'd480, 1'b0, '0});
    add_row(stim_row_t'{CMD_ADD, 17'd160, 17'd480, 1'b0, '0});
    add_row(stim_row_t'{CMD_END, 17'd0, 17'd0, 1'b0, '0});
    // center, box corners on both sides of the half-open edges, extremes
    add_row(stim_row_t'{CMD_QUERY, 17'd320, 17'd320, 1'b0, '0});
    add_row(stim_row_t'{CMD_QUERY, 17'd160, 17'd160, 1'b0, '0});
    add_row(stim_row_t'{CMD_QUERY, 17'd480, 17'd320, 1'b0, '0});
    add_row(stim_row_t'{CMD_QUERY, 17'd160, 17'd479, 1'b0, '0});
    add_row(stim_row_t'{CMD_QUERY, POS_MIN, POS_MIN, 1'b0, '0});
    add_row(stim_row_t'{CMD_QUERY, POS_MAX, POS_MAX, 1'b0, '0});
    // add and end are ignored once selected
    add_row(stim_row_t'{CMD_ADD, 17'd0, 17'd0, 1'b0, '0});
    add_row(stim_row_t'{CMD_END, 17'd0, 17'd0, 1'b0, '0});
    add_row(stim_row_t'{CMD_CLEAR, POS_MAX, POS_MIN, 1'b1,
        status_t'{1'b0, MODE_INACTIVE, 9'd0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0}});
    // add equal to the start point is skipped
    add_row(stim_row_t'{CMD_START, 17'd16, 17'd16, 1'b0, '0});
    add_row(stim_row_t'{CMD_ADD, 17'd16, 17'd16, 1'b0, '0});

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < n_rows; i++) begin
      send_item(directed_rows[i].cmd, directed_rows[i].x, directed_rows[i].y,
                directed_rows[i].typed, directed_rows[i].exp);
    end

    for (int p = 0; p < 5; p++) begin
      // canvas only changes with nothing owed
      drain();
      case (p)
        1: begin
          write_canvas(CFG_CANVAS_WIDTH, 12'd1);
          write_canvas(CFG_CANVAS_HEIGHT, 12'd4095);
          idle_pct = 83;
        end
        2: begin
          write_canvas(CFG_CANVAS_WIDTH, 12'd4095);
          write_canvas(CFG_CANVAS_HEIGHT, 12'd1);
          idle_pct = 0;
        end
        3: begin
          write_canvas(CFG_CANVAS_WIDTH, 12'd4095);
          write_canvas(CFG_CANVAS_HEIGHT, 12'd4095);
          idle_pct = 17;
        end
        4: begin
          write_canvas(CFG_CANVAS_WIDTH, CanvasW'($urandom_range(1, 4095)));
          write_canvas(CFG_CANVAS_HEIGHT, CanvasW'($urandom_range(1, 4095)));
          idle_pct = ($urandom_range(1) == 0) ? 83 : 0;
        end
        default: idle_pct = 0;
      endcase
      goal = n_sent + 300;
      // overfill the store once in a while to reach the dropped flag
      if (p == 0 || p == 2) begin
        draw_lasso(300, 6);
      end
      while (n_sent < goal) begin
        case ($urandom_range(9))
          0, 1: begin
            repeat (3) begin
              send_item(CmdW'($urandom_range(7)), PosW'($urandom), PosW'($urandom));
            end
          end
          2: drain();
          default: draw_lasso($urandom_range(0, 10), $urandom_range(1, 6));
        endcase
      end
    end

    drain();
    repeat (MAX_PTS + 8) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
design/lps_pkg.sv
design/lps_ram.sv
design/lps_ctrl.sv
design/lps_dp.sv
design/lasso_polygon_selection.sv
dv/tb_top.sv
